FILE: hdl/cursor_list_store_macros.svh
// Assertion macros used by the cursor list store top file.
`ifndef CURSOR_LIST_STORE_MACROS_SVH
`define CURSOR_LIST_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor list store: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor list store: next-cycle check failed");

`endif

FILE: hdl/cls_pkg.sv
// Types and constants of the cursor list store.
`default_nettype none

package cls_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int LIMIT_W  = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FIRST      = 3'd0,
        OP_LAST       = 3'd1,
        OP_NEXT       = 3'd2,
        OP_PRIOR      = 3'd3,
        OP_INS_BEFORE = 3'd4,
        OP_INS_AFTER  = 3'd5,
        OP_REMOVE     = 3'd6,
        OP_READ       = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_DRAIN,
        ST_COMMIT,
        ST_RDWAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EXEC,
        CMD_SHIFT,
        CMD_DRAIN,
        CMD_COMMIT,
        CMD_RDCAP
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic go_shift;
        logic go_commit;
        logic go_read;
        logic shift_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/cls_if.sv
// Valid/ready channel interfaces for list operations and their results.
`default_nettype none

interface cls_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface cls_out_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] read_value;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output ok, output read_value, output is_empty,
                    output is_full, input ready);
    modport sink (input valid, input ok, input read_value, input is_empty,
                  input is_full, output ready);
endinterface

`default_nettype wire

FILE: hdl/cls_ctrl.sv
// Sequencing state machine of the cursor list store.
`default_nettype none

module cls_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire cls_pkg::dp_status_t status,
    output cls_pkg::ctrl_cmd_t    cmd
);
    import cls_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.go_shift)
                    state_next = ST_SHIFT;
                else if (status.go_commit)
                    state_next = ST_COMMIT;
                else if (status.go_read)
                    state_next = ST_RDWAIT;
                else
                    state_next = ST_FINISH;
            end
            ST_SHIFT:
            begin
                if (status.shift_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_FINISH;
            ST_RDWAIT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.code = CMD_NONE;
        out_load = 1'b0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.code = CMD_LOAD;
            end
            ST_EXEC:   cmd.code = CMD_EXEC;
            ST_SHIFT:  cmd.code = CMD_SHIFT;
            ST_DRAIN:  cmd.code = CMD_DRAIN;
            ST_COMMIT: cmd.code = CMD_COMMIT;
            ST_RDWAIT: cmd.code = CMD_RDCAP;
            ST_FINISH: out_load = !out_valid_reg || out_ready;
            default:   cmd.code = CMD_NONE;
        endcase
        cmd.out_load = out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/cls_datapath.sv
// Entry store, count, cursor and result registers of the cursor list store.
`default_nettype none

module cls_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_wdata,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [31:0] value,
    input  wire cls_pkg::ctrl_cmd_t cmd,
    output cls_pkg::dp_status_t     status,
    output logic                    ok,
    output logic signed [31:0]      read_value,
    output logic                    is_empty,
    output logic                    is_full
);
    import cls_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   cursor_reg;
    logic [LIMIT_W-1:0] limit_reg;

    op_t                op_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]   end_reg;
    logic [IDX_W-1:0]   wr_addr_reg;
    logic               wr_pend_reg;
    logic               res_ok_reg;
    logic [VALUE_W-1:0] res_rd_reg;
    logic               out_ok_reg;
    logic [VALUE_W-1:0] out_rd_reg;
    logic               out_empty_reg;
    logic               out_full_reg;

    logic               empty;
    logic               full;
    logic [CNT_W-1:0]   cur_cnt;
    logic [CNT_W-1:0]   cur_inc;
    logic               has_next;
    logic               is_insert;
    logic [CNT_W-1:0]   ins_pos_cnt;
    logic               ins_shift;
    logic               exec_ok;
    logic               shift_last;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    always_comb
    begin
        empty     = (count_reg == '0);
        // A limit above the store depth is clipped to the depth.
        full      = (LW'(count_reg) >= LW'(limit_reg)) || (count_reg >= CNT_W'(CAPACITY));
        cur_cnt   = CNT_W'(cursor_reg);
        cur_inc   = cur_cnt + 1'b1;
        has_next  = (cur_inc < count_reg);
        is_insert = (op_reg == OP_INS_BEFORE) || (op_reg == OP_INS_AFTER);
        if (empty)
            ins_pos_cnt = '0;
        else if (op_reg == OP_INS_BEFORE)
            ins_pos_cnt = cur_cnt;
        else
            ins_pos_cnt = cur_inc;
        ins_shift  = (ins_pos_cnt < count_reg);
        shift_last = (rd_addr_reg == end_reg);

        unique case (op_reg)
            OP_FIRST, OP_LAST:         exec_ok = !empty;
            OP_NEXT:                   exec_ok = !empty && has_next;
            OP_PRIOR:                  exec_ok = !empty && (cursor_reg != '0);
            OP_INS_BEFORE, OP_INS_AFTER: exec_ok = !full;
            OP_REMOVE, OP_READ:        exec_ok = !empty;
            default:                   exec_ok = 1'b0;
        endcase

        status.go_shift   = (is_insert && !full && ins_shift)
                         || ((op_reg == OP_REMOVE) && !empty && has_next);
        status.go_commit  = (is_insert && !full && !ins_shift)
                         || ((op_reg == OP_REMOVE) && !empty && !has_next);
        status.go_read    = (op_reg == OP_READ) && !empty;
        status.shift_last = shift_last;
    end

    // One write and one registered read per cycle; the shift reads one entry
    // while writing the one read in the cycle before to its new place.
    always_comb
    begin
        mem_we    = ((cmd.code == CMD_SHIFT) && wr_pend_reg) || (cmd.code == CMD_DRAIN)
                 || ((cmd.code == CMD_COMMIT) && is_insert);
        mem_waddr = (cmd.code == CMD_COMMIT) ? pos_reg : wr_addr_reg;
        mem_wdata = (cmd.code == CMD_COMMIT) ? val_reg : rdata_reg;
        mem_raddr = (cmd.code == CMD_EXEC) ? cursor_reg : rd_addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cursor_reg  <= '0;
            limit_reg   <= LIMIT_RESET;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            case (cmd.code)
                CMD_EXEC:
                begin
                    wr_pend_reg <= 1'b0;
                    case (op_reg)
                        OP_FIRST:
                        begin
                            if (!empty)
                                cursor_reg <= '0;
                        end
                        OP_LAST:
                        begin
                            if (!empty)
                                cursor_reg <= IDX_W'(count_reg - 1'b1);
                        end
                        OP_NEXT:
                        begin
                            if (!empty && has_next)
                                cursor_reg <= cursor_reg + 1'b1;
                        end
                        OP_PRIOR:
                        begin
                            if (!empty && (cursor_reg != '0))
                                cursor_reg <= cursor_reg - 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_SHIFT:
                begin
                    wr_pend_reg <= 1'b1;
                end
                CMD_COMMIT:
                begin
                    if (is_insert)
                    begin
                        count_reg  <= count_reg + 1'b1;
                        cursor_reg <= pos_reg;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        // Removing the last entry pulls the cursor back one.
                        if ((cur_inc == count_reg) && (cursor_reg != '0))
                            cursor_reg <= cursor_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.code)
            CMD_LOAD:
            begin
                op_reg  <= op_t'(opcode);
                val_reg <= value;
            end
            CMD_EXEC:
            begin
                res_ok_reg <= exec_ok;
                res_rd_reg <= '0;
                if (op_reg == OP_REMOVE)
                begin
                    pos_reg     <= cursor_reg;
                    rd_addr_reg <= IDX_W'(cur_inc);
                    end_reg     <= IDX_W'(count_reg - 1'b1);
                end
                else
                begin
                    pos_reg     <= IDX_W'(ins_pos_cnt);
                    rd_addr_reg <= IDX_W'(count_reg - 1'b1);
                    end_reg     <= IDX_W'(ins_pos_cnt);
                end
            end
            CMD_SHIFT:
            begin
                if (is_insert)
                begin
                    wr_addr_reg <= rd_addr_reg + 1'b1;
                    if (!shift_last)
                        rd_addr_reg <= rd_addr_reg - 1'b1;
                end
                else
                begin
                    wr_addr_reg <= rd_addr_reg - 1'b1;
                    if (!shift_last)
                        rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end
            CMD_RDCAP:
            begin
                res_rd_reg <= rdata_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_rd_reg    <= res_rd_reg;
            out_empty_reg <= empty;
            out_full_reg  <= full;
        end
    end

    assign ok         = out_ok_reg;
    assign read_value = signed'(out_rd_reg);
    assign is_empty   = out_empty_reg;
    assign is_full    = out_full_reg;

endmodule

`default_nettype wire

FILE: hdl/cursor_list_store.sv
// Ordered list of signed words with a cursor: ingress on item, results on result.
// Each transfer on item carries an opcode (first, last, next, prior, insert before,
// insert after, remove, read) and a value used only by the inserts. Every item gives
// exactly one transfer on result with ok, read_value, is_empty and is_full.
// One item is worked on at a time; item.ready is high only while the block is idle.
// Moves and refused operations go from ST_EXEC straight to ST_FINISH; a read passes ST_RDWAIT.
// Insert and remove move the entries behind the insertion or removal point through
// the store one per cycle in ST_SHIFT, then pass ST_DRAIN and ST_COMMIT; at most
// CAPACITY - 1 entries move, and when none move they go from ST_EXEC to ST_COMMIT.
// The result sits in an output register; the next item is taken while it waits, and
// that item's result is held back until the waiting one has been transferred.
// cfg_we writes the capacity limit from cfg_wdata; write it only while idle.
// Reset clears the list, the cursor and the result channel and sets the limit to 64;
// stored words are not cleared, and no entry is read before it has been written.
`default_nettype none
`include "cursor_list_store_macros.svh"

module cursor_list_store #(
    parameter int CAPACITY = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    cls_in_if.sink          item,
    cls_out_if.source       result
);
    import cls_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;

    cls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cls_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .opcode     (item.opcode),
        .value      (item.value),
        .cmd        (cmd),
        .status     (status),
        .ok         (result.ok),
        .read_value (result.read_value),
        .is_empty   (result.is_empty),
        .is_full    (result.is_full)
    );

    assign item.ready   = in_ready;
    assign result.valid = out_valid;

    `CLS_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, item.valid && item.ready, !item.ready)
    `CLS_ASSERT_NOW(a_no_intake_while_shifting, clk, rst_n, cmd.code == CMD_SHIFT, !item.ready)
    `CLS_ASSERT_NOW(a_refused_reads_zero, clk, rst_n, result.valid && !result.ok, result.read_value == 32'sd0)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the cursor list store: directed, limit and random traffic.
`timescale 1ns / 100ps

module tb_top;
    import cls_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] read_value;
        logic               is_empty;
        logic               is_full;
    } list_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    cls_in_if  item_ch ();
    cls_out_if result_ch ();

    cursor_list_store #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .item     (item_ch),
        .result   (result_ch)
    );

    // Shadow copy of the list held by the block.
    logic [31:0]  shadow_words [LIST_DEPTH];
    int           shadow_count;
    int           shadow_cursor;
    logic [6:0]   shadow_limit;

    list_result_t pending_results[$];
    int           mismatch_count = 0;
    int           sender_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles = 0;

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic list_result_t apply_list_op(op_t op, logic signed [31:0] word);
        list_result_t r;
        int           cur;
        int           pos;
        int           lim;
        int           i;
        r = '0;
        lim = (shadow_limit > LIST_DEPTH) ? LIST_DEPTH : int'(shadow_limit);
        cur = (shadow_count == 0) ? 0 : shadow_cursor;
        case (op)
            OP_FIRST:
                if (shadow_count != 0)
                begin
                    shadow_cursor = 0;
                    r.ok = 1'b1;
                end
            OP_LAST:
                if (shadow_count != 0)
                begin
                    shadow_cursor = shadow_count - 1;
                    r.ok = 1'b1;
                end
            OP_NEXT:
                if (shadow_count != 0 && cur + 1 < shadow_count)
                begin
                    shadow_cursor = shadow_cursor + 1;
                    r.ok = 1'b1;
                end
            OP_PRIOR:
                if (shadow_count != 0 && cur > 0)
                begin
                    shadow_cursor = shadow_cursor - 1;
                    r.ok = 1'b1;
                end
            OP_INS_BEFORE, OP_INS_AFTER:
                if (shadow_count < lim)
                begin
                    if (shadow_count == 0)
                        pos = 0;
                    else
                        pos = (op == OP_INS_BEFORE) ? cur : cur + 1;
                    for (i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = word;
                    shadow_count = shadow_count + 1;
                    shadow_cursor = pos;
                    r.ok = 1'b1;
                end
            OP_REMOVE:
                if (shadow_count != 0)
                begin
                    for (i = cur; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count = shadow_count - 1;
                    // The cursor steps back when it sat on the last entry.
                    if (cur == shadow_count)
                        shadow_cursor = shadow_cursor - 1;
                    r.ok = 1'b1;
                end
            default:
                if (shadow_count != 0)
                begin
                    r.read_value = shadow_words[cur];
                    r.ok = 1'b1;
                end
        endcase
        r.is_empty = (shadow_count == 0);
        r.is_full = (shadow_count >= lim);
        return r;
    endfunction

    task automatic send_op(op_t op, logic signed [31:0] word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.opcode <= op;
        item_ch.value <= word;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_results.push_back(apply_list_op(op, word));
    endtask

    task automatic wait_until_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_capacity_limit(logic [6:0] limit);
        wait_until_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_limit = limit;
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_op(bit growing);
        int roll;
        roll = $urandom_range(99);
        if (roll < (growing ? 50 : 15))
            return $urandom_range(1) ? OP_INS_BEFORE : OP_INS_AFTER;
        else if (roll < (growing ? 60 : 55))
            return OP_REMOVE;
        else if (roll < 80)
            return op_t'(OPCODE_W'($urandom_range(3)));
        else
            return OP_READ;
    endfunction

    task automatic report_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin : result_checker
        list_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_failure($sformatf("result with no item waiting at %0t", $realtime));
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.ok !== want.ok || result_ch.read_value !== want.read_value ||
                    result_ch.is_empty !== want.is_empty || result_ch.is_full !== want.is_full)
                    report_failure($sformatf(
                        "mismatch at %0t: ok %b/%b read %0d/%0d empty %b/%b full %b/%b",
                        $realtime, want.ok, result_ch.ok, want.read_value,
                        result_ch.read_value, want.is_empty, result_ch.is_empty,
                        want.is_full, result_ch.is_full));
            end
        end
    end

    // Ends the run when neither channel sees a transfer for too long.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL cursor_list_store");
            $finish;
        end
    end

    task automatic test_empty_and_edges();
        send_op(OP_FIRST, 32'sd1);
        send_op(OP_LAST, 32'sd2);
        send_op(OP_NEXT, 32'sd3);
        send_op(OP_PRIOR, 32'sd4);
        send_op(OP_REMOVE, 32'sd5);
        send_op(OP_READ, 32'sd6);
        // Insert after on an empty list lands at position zero.
        send_op(OP_INS_AFTER, 32'sh7FFF_FFFF);
        send_op(OP_INS_BEFORE, 32'sh8000_0000);
        send_op(OP_READ, 32'sd0);
        send_op(OP_PRIOR, 32'sd0);
        send_op(OP_INS_AFTER, 32'sd0);
        send_op(OP_INS_AFTER, -32'sd1);
        send_op(OP_NEXT, 32'sd0);
        send_op(OP_LAST, 32'sd0);
        send_op(OP_REMOVE, 32'sd0);
        send_op(OP_READ, 32'sd0);
        send_op(OP_FIRST, 32'sd0);
        send_op(OP_NEXT, 32'sd0);
        send_op(OP_READ, 32'sd0);
        send_op(OP_REMOVE, 32'sd0);
        send_op(OP_READ, 32'sd0);
        send_op(OP_REMOVE, 32'sd0);
        send_op(OP_REMOVE, 32'sd0);
        send_op(OP_READ, 32'sd0);
    endtask

    task automatic test_capacity_limits();
        int n;
        // With a limit of zero the list counts as full at all times.
        set_capacity_limit(7'd0);
        send_op(OP_INS_BEFORE, 32'sd11);
        send_op(OP_INS_AFTER, 32'sd12);
        send_op(OP_READ, 32'sd0);
        set_capacity_limit(7'd1);
        send_op(OP_INS_BEFORE, pick_word());
        send_op(OP_INS_AFTER, pick_word());
        send_op(OP_READ, 32'sd0);
        send_op(OP_REMOVE, 32'sd0);
        // A limit above the store depth is clipped to the depth.
        set_capacity_limit(7'd127);
        for (n = 0; n < LIST_DEPTH; n++)
            send_op((n % 3 == 0) ? OP_INS_BEFORE : OP_INS_AFTER, pick_word());
        send_op(OP_INS_AFTER, pick_word());
        send_op(OP_FIRST, 32'sd0);
        send_op(OP_READ, 32'sd0);
        send_op(OP_LAST, 32'sd0);
        send_op(OP_READ, 32'sd0);
        // Lowering the limit below the count keeps the list full.
        set_capacity_limit(7'd9);
        send_op(OP_INS_BEFORE, pick_word());
        send_op(OP_FIRST, 32'sd0);
        send_op(OP_REMOVE, 32'sd0);
        while (shadow_count > 4)
            send_op(OP_REMOVE, 32'sd0);
        send_op(OP_INS_AFTER, pick_word());
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, logic [6:0] limit_a,
                                       logic [6:0] limit_b, int item_total);
        int n;
        bit growing;
        growing = 1'b1;
        set_capacity_limit(limit_a);
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < item_total; n++)
        begin
            if (n == item_total / 2)
            begin
                set_capacity_limit(limit_b);
            end
            if ($urandom_range(39) == 0)
                growing = !growing;
            send_op(pick_op(growing), pick_word());
        end
        wait_until_idle();
        sender_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 7'd0;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_FIRST;
        item_ch.value = 32'sd0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_count = 0;
        shadow_cursor = -1;
        shadow_limit = LIMIT_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_edges();
        test_capacity_limits();
        test_random_traffic(0, 0, 7'd127, 7'($urandom_range(2, 16)), 450);
        test_random_traffic(74, 0, 7'd64, 7'd3, 450);
        test_random_traffic(0, 74, 7'($urandom_range(1, 64)), 7'd100, 450);
        test_random_traffic(27, 27, 7'd1, 7'd64, 450);

        wait_until_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS cursor_list_store");
        else
            $display("FAIL cursor_list_store");
        $finish;
    end

endmodule

FILE: cursor_list_store.f
+incdir+hdl
hdl/cls_pkg.sv
hdl/cls_if.sv
hdl/cls_ctrl.sv
hdl/cls_datapath.sv
hdl/cursor_list_store.sv
tb/tb_top.sv
